// ----- rtl/ats_pkg.sv -----
// ----------------------------------------------------------------------------
// ats_pkg
// Shared constants for the arctangent series pipeline: term count and the
// fixed-point format of arguments, powers and results.
// ----------------------------------------------------------------------------
package ats_pkg;

   // number of series terms, one pipeline stage each
   localparam int TERMS     = 20;
   // fraction bits of the signed fixed-point format
   localparam int FRAC_BITS = 30;
   // width of the argument and result fields
   localparam int XW        = FRAC_BITS + 2;
   // width of a magnitude that is at most 1.0
   localparam int MAG_W     = FRAC_BITS + 1;
   // width of the exact product of two magnitudes
   localparam int PROD_W    = 2 * MAG_W;

   // 1.0 as a field-wide magnitude
   localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;

endpackage

// ----- rtl/arctan_taylor_series.sv -----
// ----------------------------------------------------------------------------
// arctan_taylor_series
// Maclaurin partial sum x - x^3/3 + x^5/5 - ... of ats_pkg::TERMS terms on a
// signed Q2.30 argument, result in the same format.
//
// The unit takes one argument in every clock cycle and never asserts busy.
// Each result appears on rsp_arctan_out and rsp_range_error for one cycle,
// marked by rsp_valid, after the start beat has passed the input, magnitude
// and x squared stages, one multiply stage per series term and the output
// register. The receiver cannot stall, so results must be taken as they come.
// An argument with magnitude above 1.0 gives zero with rsp_range_error set.
// Products truncate toward zero.
// ----------------------------------------------------------------------------
module arctan_taylor_series (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [ats_pkg::XW-1:0] req_x_in,
   output logic                       rsp_valid,
   output logic signed [ats_pkg::XW-1:0] rsp_arctan_out,
   output logic                       rsp_range_error
);

   localparam int TERMS  = ats_pkg::TERMS;
   localparam int XW     = ats_pkg::XW;
   localparam int MAG_W  = ats_pkg::MAG_W;
   localparam int PROD_W = ats_pkg::PROD_W;
   localparam int FB     = ats_pkg::FRAC_BITS;

   // input register
   logic                 in_valid_ff;
   logic [XW-1:0]        in_x_ff;

   // magnitude stage
   logic                 mag_valid_ff;
   logic                 mag_neg_ff;
   logic                 mag_err_ff;
   logic [MAG_W-1:0]     mag_ff;
   logic [XW-1:0]        mag_abs_in;
   logic                 mag_err_in;
   logic [PROD_W-1:0]    sq_prod;

   // term stages, index k feeds term k
   logic                 v_ff    [0:TERMS];
   logic                 neg_ff  [0:TERMS];
   logic                 err_ff  [0:TERMS];
   logic signed [XW-1:0] sum_ff  [0:TERMS];
   logic [MAG_W-1:0]     term_ff [0:TERMS];
   logic                 tneg_ff [0:TERMS];
   logic [MAG_W-1:0]     pw_ff   [0:TERMS-1];
   logic [MAG_W-1:0]     x2_ff   [0:TERMS-1];
   logic [PROD_W-1:0]    term_prod [0:TERMS-1];
   logic [PROD_W-1:0]    pw_prod   [0:TERMS-1];

   // output sum
   logic signed [XW-1:0] out_sum_in;

   // the pipeline never holds off a beat
   assign busy = 1'b0;

   // magnitude and range check
   always_comb begin
      mag_abs_in = in_x_ff[XW-1] ? (~in_x_ff + XW'(1)) : in_x_ff;
      mag_err_in = (mag_abs_in > ats_pkg::ONE_X);
   end

   // x squared
   assign sq_prod = PROD_W'(mag_ff) * PROD_W'(mag_ff);

   // per-term multipliers: reciprocal scaling and next odd power
   for (genvar g = 0; g < TERMS; g++) begin : g_term
      localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'(1) << FB) / (2 * g + 1));
      assign term_prod[g] = PROD_W'(pw_ff[g]) * PROD_W'(RECIP);
      if (g < TERMS - 1) begin : g_pw
         assign pw_prod[g] = PROD_W'(pw_ff[g]) * PROD_W'(x2_ff[g]);
      end else begin : g_last
         assign pw_prod[g] = '0;
      end
   end

   // final add of the last term
   always_comb begin
      if (tneg_ff[TERMS]) begin
         out_sum_in = sum_ff[TERMS] - $signed({1'b0, term_ff[TERMS]});
      end else begin
         out_sum_in = sum_ff[TERMS] + $signed({1'b0, term_ff[TERMS]});
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mag_valid_ff <= 1'b0;
         for (int k = 0; k <= TERMS; k++) begin
            v_ff[k] <= 1'b0;
         end
         rsp_valid <= 1'b0;
      end else begin
         in_valid_ff  <= start & ~busy;
         mag_valid_ff <= in_valid_ff;
         v_ff[0]      <= mag_valid_ff;
         for (int k = 1; k <= TERMS; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         rsp_valid <= v_ff[TERMS];
      end
   end

   // data path
   always_ff @(posedge clock) begin
      in_x_ff <= req_x_in;

      mag_neg_ff <= in_x_ff[XW-1];
      mag_err_ff <= mag_err_in;
      mag_ff     <= mag_err_in ? '0 : mag_abs_in[MAG_W-1:0];

      neg_ff[0]  <= mag_neg_ff;
      err_ff[0]  <= mag_err_ff;
      sum_ff[0]  <= '0;
      term_ff[0] <= '0;
      tneg_ff[0] <= 1'b0;
      pw_ff[0]   <= mag_ff;
      x2_ff[0]   <= sq_prod[FB +: MAG_W];

      // stage k: scale power k, accumulate term k-1
      for (int k = 0; k < TERMS; k++) begin
         neg_ff[k+1]  <= neg_ff[k];
         err_ff[k+1]  <= err_ff[k];
         term_ff[k+1] <= term_prod[k][FB +: MAG_W];
         tneg_ff[k+1] <= neg_ff[k] ^ (k % 2 == 1);
         if (tneg_ff[k]) begin
            sum_ff[k+1] <= sum_ff[k] - $signed({1'b0, term_ff[k]});
         end else begin
            sum_ff[k+1] <= sum_ff[k] + $signed({1'b0, term_ff[k]});
         end
      end

      // next odd power and x squared move along
      for (int k = 1; k < TERMS; k++) begin
         pw_ff[k] <= pw_prod[k-1][FB +: MAG_W];
         x2_ff[k] <= x2_ff[k-1];
      end

      rsp_range_error <= err_ff[TERMS];
      rsp_arctan_out  <= err_ff[TERMS] ? '0 : out_sum_in;
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for arctan_taylor_series. Signed fixed-point
// arguments are fed over the start/busy command port, directed corner values
// first and then about 1300 random ones, most of them inside [-1, +1]. A
// scoreboard works out each partial sum on its own and compares every result
// beat with the oldest pending expectation. Sender gaps come in bursts and
// in random lengths, and the sender drains the pipeline now and then.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic signed [ats_pkg::XW-1:0] sum;
      logic                          range_err;
   } arctan_result_type;

   // scoreboard: predicts one result per argument and checks result beats
   class arctan_scoreboard;
      arctan_result_type pending_sums[$];
      int                fail_count;
      int                shown;

      function new();
         fail_count = 0;
         shown      = 0;
      endfunction

      // truncating fixed-point product of two magnitudes
      function longint unsigned fx_mul(longint unsigned a, longint unsigned b);
         logic [127:0] prod;
         prod = {64'd0, a} * {64'd0, b};
         return prod[ats_pkg::FRAC_BITS +: 64];
      endfunction

      // alternating series on the magnitude, sign applied per term
      function arctan_result_type arctan_series(logic [ats_pkg::XW-1:0] x);
         arctan_result_type    res;
         logic                 neg;
         logic [ats_pkg::XW:0] mag;
         longint unsigned      one_mag, pw, x_sq, recip, term;
         longint               acc;
         neg     = x[ats_pkg::XW-1];
         mag     = neg ? ((33'd1 << ats_pkg::XW) - {1'b0, x}) : {1'b0, x};
         one_mag = 64'd1 << ats_pkg::FRAC_BITS;
         acc     = 0;
         if (64'(mag) > one_mag) begin
            res.sum       = '0;
            res.range_err = 1'b1;
            return res;
         end
         pw   = 64'(mag);
         x_sq = fx_mul(64'(mag), 64'(mag));
         for (int k = 0; k < ats_pkg::TERMS; k++) begin
            recip = one_mag / longint'(2 * k + 1);
            term  = fx_mul(pw, recip);
            if (neg ^ k[0])
               acc -= longint'(term);
            else
               acc += longint'(term);
            pw = fx_mul(pw, x_sq);
         end
         res.sum       = acc[ats_pkg::XW-1:0];
         res.range_err = 1'b0;
         return res;
      endfunction

      function void note_arg(logic [ats_pkg::XW-1:0] x);
         pending_sums.push_back(arctan_series(x));
      endfunction

      function void check_result(logic [ats_pkg::XW-1:0] sum, logic range_err);
         arctan_result_type exp_res;
         if (pending_sums.size() == 0) begin
            fail_count++;
            if (shown < 10) begin
               shown++;
               $display("unexpected result beat: sum=%h range_error=%b", sum, range_err);
            end
            return;
         end
         exp_res = pending_sums.pop_front();
         if (sum !== exp_res.sum || range_err !== exp_res.range_err) begin
            fail_count++;
            if (shown < 10) begin
               shown++;
               $display("mismatch: sum exp %h got %h, range_error exp %b got %b",
                        exp_res.sum, sum, exp_res.range_err, range_err);
            end
         end
      endfunction

      function int pending();
         return pending_sums.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [ats_pkg::XW-1:0] req_x_in;
   logic                          rsp_valid;
   logic signed [ats_pkg::XW-1:0] rsp_arctan_out;
   logic                          rsp_range_error;

   arctan_scoreboard sb = new();

   arctan_taylor_series i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_in        (req_x_in),
      .rsp_valid       (rsp_valid),
      .rsp_arctan_out  (rsp_arctan_out),
      .rsp_range_error (rsp_range_error)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // monitor: results are checked before the argument of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(rsp_arctan_out, rsp_range_error);
         if (start && !busy)
            sb.note_arg(req_x_in);
      end
   end

   // mostly short gaps, a few long ones, none at all in a burst
   function automatic int pick_gap(bit burst);
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(5, 40);
   endfunction

   // random argument: mostly in range, some near the boundary, some anywhere
   function automatic logic [ats_pkg::XW-1:0] pick_arg();
      int                   roll;
      logic [ats_pkg::XW:0] mag;
      roll = $urandom_range(0, 99);
      if (roll < 20)
         return $urandom();
      if (roll < 30)
         mag = (ats_pkg::XW + 1)'($urandom_range((1 << ats_pkg::FRAC_BITS) - 16,
                                                 (1 << ats_pkg::FRAC_BITS) + 16));
      else if (roll < 40)
         mag = (ats_pkg::XW + 1)'($urandom_range(0,
                  1 << ($urandom_range(0, ats_pkg::FRAC_BITS - 1))));
      else
         mag = (ats_pkg::XW + 1)'($urandom_range(0, 1 << ats_pkg::FRAC_BITS));
      return $urandom_range(0, 1) ? -mag[ats_pkg::XW-1:0] : mag[ats_pkg::XW-1:0];
   endfunction

   // one command beat, then an optional idle gap
   task automatic send_arg(input logic [ats_pkg::XW-1:0] x, input int gap);
      start    <= 1'b1;
      req_x_in <= x;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [ats_pkg::XW-1:0] corner_args[$];
      bit                     burst;
      corner_args = '{32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h4000_0001,
                      32'hBFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                      32'hFFFF_FFFF, 32'h2000_0000, 32'hE000_0000, 32'h3FFF_FFFF,
                      32'hC000_0001, 32'h8000_0001, 32'h1000_0000, 32'hF000_0000,
                      32'h2D41_3CCD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000,
                      32'hFFFF_8000};
      reset    <= 1'b1;
      start    <= 1'b0;
      req_x_in <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corner values: +-1.0, just past it, most negative, tiny magnitudes
      foreach (corner_args[i])
         send_arg(corner_args[i], pick_gap(i < 8));
      start <= 1'b0;
      drain();

      // random arguments in phases that alternate bursts and gaps
      burst = 1'b0;
      for (int n = 0; n < 1300; n++) begin
         if (n % 100 == 0)
            burst = $urandom_range(0, 2) == 0;
         send_arg(pick_arg(), pick_gap(burst));
         // sender holds off until the pipeline is empty
         if (n % 300 == 299) begin
            start <= 1'b0;
            drain();
         end
      end

      start <= 1'b0;
      drain();
      repeat (ats_pkg::TERMS + 10) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("arctan_taylor_series regression: pass");
      else
         $display("arctan_taylor_series regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("arctan_taylor_series regression: fail");
      $finish;
   end

endmodule

// ----- arctan_taylor_series.f -----
rtl/ats_pkg.sv
rtl/arctan_taylor_series.sv
tb/sv/testbench.sv
